FILE: sv/vertex_dedup_index_builder_macros.svh
// Assertion macros for the vertex deduplication index builder.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef VERTEX_DEDUP_INDEX_BUILDER_MACROS_SVH
`define VERTEX_DEDUP_INDEX_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
`define VDIB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vdib check failed");
`define VDIB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdib sequence check failed");
`else
`define VDIB_ASSERT(lbl, prop)
`define VDIB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/vdib_pkg.sv
// Shared constants, types and helpers for the vertex deduplication index builder.
// No dependencies.
package vdib_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W        = 10;
  localparam int TOL_W        = 31;
  localparam int COORD_W      = 32;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TOL_W-1:0]  tol_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t u;
    coord_t v;
  } vertex_t;

  // The result index carries the low bits of the table address.
  function automatic idx_t to_idx(input addr_t a);
    return IDX_W'(a);
  endfunction

endpackage

FILE: sv/vdib_cmp.sv
// Five-lane closeness test between an incoming vertex and one stored entry.
// Depends on vdib_pkg.
module vdib_cmp (
  input  vdib_pkg::vertex_t in_vtx,
  input  vdib_pkg::vertex_t entry,
  input  vdib_pkg::tol_t    tol,
  output logic              match
);
  import vdib_pkg::*;

  localparam int DW = COORD_W + 3;

  // |a - b| < t holds exactly when both a - b - t and b - a - t are negative.
  function automatic logic close(input coord_t a, input coord_t b, input tol_t t);
    logic signed [DW-1:0] sa;
    logic signed [DW-1:0] sb;
    logic signed [DW-1:0] st;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
    sa = DW'(a);
    sb = DW'(b);
    st = DW'({1'b0, t});
    d1 = sa - sb - st;
    d2 = sb - sa - st;
    return d1[DW-1] & d2[DW-1];
  endfunction

  assign match = close(in_vtx.x, entry.x, tol) & close(in_vtx.y, entry.y, tol) &
                 close(in_vtx.z, entry.z, tol) & close(in_vtx.u, entry.u, tol) &
                 close(in_vtx.v, entry.v, tol);

endmodule

FILE: sv/vertex_dedup_index_builder.sv
// Top level of the vertex deduplication index builder: vertex table memory and scan control.
// Depends on vdib_pkg, vdib_cmp and vertex_dedup_index_builder_macros.svh.
//
// Usage: raise start with a vertex on the in_ ports while busy is low; that beat is taken.
// in_start_mesh empties the table before the vertex is handled. The block scans the
// stored unique vertices in insertion order through one single-port table memory, one
// entry per cycle, and stops at the first entry within cfg_match_tolerance on all five
// coordinates. With no match the vertex is appended, or table_overflow is flagged when
// the table is full. Exactly one result per vertex appears on the out_ ports for one
// cycle with out_valid high; the receiver cannot stall, so it must take it then.
// busy drops at the edge that produces the result, so the next beat can be taken
// while out_valid is high; a new vertex is not taken until the last one has its result.
// cfg_match_tolerance is written through its valid/ready channel while idle. Reset sets
// the tolerance to 655 (about 0.01) and empties the table; no clearing pass is needed
// since only written entries are read.
module vertex_dedup_index_builder (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_start_mesh,
  input  vdib_pkg::coord_t       in_pos_x,
  input  vdib_pkg::coord_t       in_pos_y,
  input  vdib_pkg::coord_t       in_pos_z,
  input  vdib_pkg::coord_t       in_tex_u,
  input  vdib_pkg::coord_t       in_tex_v,
  output logic                   out_valid,
  output vdib_pkg::idx_t         out_vertex_index,
  output logic                   out_is_new,
  output logic                   out_table_overflow,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  vdib_pkg::tol_t         cfg_match_tolerance
);
  import vdib_pkg::*;
  `include "vertex_dedup_index_builder_macros.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic    state_r, state_nxt;
  cnt_t    cnt_r, cnt_nxt;
  cnt_t    next_addr_r, next_addr_nxt;
  logic    issuing_r, issuing_nxt;
  logic    cmp_vld_r, cmp_vld_nxt;
  addr_t   cmp_idx_r, cmp_idx_nxt;
  tol_t    tol_r;
  vertex_t vtx_r, vtx_nxt;
  logic    out_valid_r, out_valid_nxt;
  idx_t    out_idx_r, out_idx_nxt;
  logic    out_new_r, out_new_nxt;
  logic    out_ovf_r, out_ovf_nxt;

  logic    mem_re, mem_we;
  addr_t   mem_ra, mem_wa;
  vertex_t rdata_r;
  vertex_t mem [MAX_VERTICES];

  logic    accept;
  logic    match;
  logic    hit, miss_end;
  cnt_t    cnt_eff;

  assign busy      = (state_r == ST_SCAN);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  vdib_cmp u_cmp (
    .in_vtx (vtx_r),
    .entry  (rdata_r),
    .tol    (tol_r),
    .match  (match)
  );

  // Writes happen only at the edge that ends an item, and the next item's first read
  // comes at a later edge, so a read never overlaps a write of the same entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= vtx_r;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  assign hit      = cmp_vld_r & match;
  assign miss_end = (cnt_r == '0) |
                    (cmp_vld_r & ~match & ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == cnt_r));
  assign cnt_eff  = in_start_mesh ? '0 : cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    next_addr_nxt = next_addr_r;
    issuing_nxt   = issuing_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    vtx_nxt       = vtx_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_ovf_nxt   = out_ovf_r;
    mem_re        = 1'b0;
    mem_ra        = '0;
    mem_we        = 1'b0;
    mem_wa        = cnt_r[ADDR_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          vtx_nxt   = '{x: in_pos_x, y: in_pos_y, z: in_pos_z, u: in_tex_u, v: in_tex_v};
          cnt_nxt   = cnt_eff;
          state_nxt = ST_SCAN;
          if (cnt_eff != '0) begin
            mem_re        = 1'b1;
            cmp_vld_nxt   = 1'b1;
            cmp_idx_nxt   = '0;
            next_addr_nxt = CNT_W'(1);
            issuing_nxt   = (cnt_eff > CNT_W'(1));
          end else begin
            issuing_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = to_idx(cmp_idx_r);
          out_new_nxt   = 1'b0;
          out_ovf_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (miss_end) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (cnt_r == CNT_W'(MAX_VERTICES)) begin
            out_idx_nxt = '0;
            out_new_nxt = 1'b0;
            out_ovf_nxt = 1'b1;
          end else begin
            mem_we      = 1'b1;
            cnt_nxt     = cnt_r + CNT_W'(1);
            out_idx_nxt = to_idx(cnt_r[ADDR_W-1:0]);
            out_new_nxt = 1'b1;
            out_ovf_nxt = 1'b0;
          end
        end else if (issuing_r) begin
          mem_re        = 1'b1;
          mem_ra        = next_addr_r[ADDR_W-1:0];
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = next_addr_r[ADDR_W-1:0];
          next_addr_nxt = next_addr_r + CNT_W'(1);
          issuing_nxt   = ((next_addr_r + CNT_W'(1)) < cnt_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      next_addr_r <= '0;
      issuing_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      tol_r       <= TOL_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      next_addr_r <= next_addr_nxt;
      issuing_r   <= issuing_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_match_tolerance;
      end
    end
  end

  always_ff @(posedge clk) begin
    vtx_r     <= vtx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    out_idx_r <= out_idx_nxt;
    out_new_r <= out_new_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_vertex_index   = out_idx_r;
  assign out_is_new         = out_new_r;
  assign out_table_overflow = out_ovf_r;

  `VDIB_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(MAX_VERTICES))
  `VDIB_ASSERT_NXT(a_result_ends_scan, state_r == ST_SCAN && (hit || miss_end),
                   out_valid && state_r == ST_IDLE)
  `VDIB_ASSERT(a_flags_exclusive, !(out_valid && out_is_new && out_table_overflow))
  `VDIB_ASSERT(a_ovf_full, !(out_valid && out_table_overflow) ||
                           cnt_r == CNT_W'(MAX_VERTICES))
  `VDIB_ASSERT(a_read_in_range, !(cmp_vld_r && state_r == ST_SCAN) ||
                                CNT_W'(cmp_idx_r) < cnt_r)

endmodule
